// File: rtl/clnws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clnws_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int OP_IDX_W    = 4;
  localparam int SUB_W       = 3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       rs_select;
  } item_t;

  typedef struct packed {
    logic        rs_line;
    logic        enable_line;
    logic [3:0]  data_nibble;
    logic [15:0] hold_us;
    logic        last;
  } result_t;

  localparam logic [1:0] FUNC_BYTE   = 2'd0;
  localparam logic [1:0] FUNC_NIBBLE = 2'd1;
  localparam logic [1:0] FUNC_INIT   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_PULSE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CMD_WAIT = 2'd2;

  localparam logic [7:0] PULSE_RESET    = 8'd2;
  localparam logic [7:0] GAP_RESET      = 8'd5;
  localparam logic [9:0] CMD_WAIT_RESET = 10'd50;

  localparam logic [15:0] WAIT_POWER_US = 16'd50000;
  localparam logic [15:0] WAIT_SHORT_US = 16'd50;
  localparam logic [15:0] WAIT_LONG_US  = 16'd10000;

  localparam logic [SUB_W-1:0] SUB_HI_ON    = 3'd0;
  localparam logic [SUB_W-1:0] SUB_HI_OFF   = 3'd1;
  localparam logic [SUB_W-1:0] SUB_LO_ON    = 3'd2;
  localparam logic [SUB_W-1:0] SUB_LO_OFF   = 3'd3;
  localparam logic [SUB_W-1:0] SUB_CMD_WAIT = 3'd4;
  localparam logic [SUB_W-1:0] SUB_RELEASE  = 3'd5;

  localparam logic [OP_IDX_W-1:0] INIT_LAST_OP = 4'd11;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_STROBE,
    OP_BYTE
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
    logic        rs;
    logic [15:0] hold;
  } op_t;

  typedef struct packed {
    logic        rs_line;
    logic        enable_line;
    logic [3:0]  data_nibble;
    logic [15:0] hold_us;
    logic        op_end;
  } step_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  function automatic op_t init_op(input logic [OP_IDX_W-1:0] idx);
    op_t op;
    op = '{kind: OP_WAIT, data: 8'h00, rs: 1'b0, hold: 16'd0};
    case (idx)
      4'd0:  op = '{kind: OP_WAIT,   data: 8'h00, rs: 1'b0, hold: WAIT_POWER_US};
      4'd1:  op = '{kind: OP_STROBE, data: 8'h03, rs: 1'b0, hold: 16'd0};
      4'd2:  op = '{kind: OP_WAIT,   data: 8'h03, rs: 1'b0, hold: WAIT_SHORT_US};
      4'd3:  op = '{kind: OP_BYTE,   data: 8'h28, rs: 1'b0, hold: 16'd0};
      4'd4:  op = '{kind: OP_WAIT,   data: 8'h08, rs: 1'b0, hold: WAIT_SHORT_US};
      4'd5:  op = '{kind: OP_BYTE,   data: 8'h0E, rs: 1'b0, hold: 16'd0};
      4'd6:  op = '{kind: OP_WAIT,   data: 8'h0E, rs: 1'b0, hold: WAIT_SHORT_US};
      4'd7:  op = '{kind: OP_BYTE,   data: 8'h01, rs: 1'b0, hold: 16'd0};
      4'd8:  op = '{kind: OP_WAIT,   data: 8'h01, rs: 1'b0, hold: WAIT_LONG_US};
      4'd9:  op = '{kind: OP_BYTE,   data: 8'h06, rs: 1'b0, hold: 16'd0};
      4'd10: op = '{kind: OP_WAIT,   data: 8'h06, rs: 1'b0, hold: WAIT_LONG_US};
      4'd11: op = '{kind: OP_BYTE,   data: 8'h0C, rs: 1'b0, hold: 16'd0};
      default: op = '{kind: OP_WAIT, data: 8'h00, rs: 1'b0, hold: 16'd0};
    endcase
    return op;
  endfunction

  function automatic logic [SUB_W-1:0] first_sub(input op_kind_t kind);
    return (kind == OP_STROBE) ? SUB_LO_ON : SUB_HI_ON;
  endfunction

endpackage

`default_nettype wire

// File: rtl/clnws_step.sv
`timescale 1ns / 1ps
`default_nettype none

module clnws_step (
  input  clnws_pkg::op_t                   op,
  input  logic [clnws_pkg::SUB_W-1:0]      sub,
  input  logic [7:0]                       pulse_us,
  input  logic [7:0]                       gap_us,
  input  logic [9:0]                       cmd_wait_us,
  output clnws_pkg::step_t                 step
);

  logic [15:0] add_a;
  logic [15:0] add_b;

  always_comb begin
    add_a            = 16'd0;
    add_b            = 16'd0;
    step.rs_line     = 1'b0;
    step.enable_line = 1'b0;
    step.data_nibble = op.data[3:0];
    step.op_end      = 1'b0;
    if (op.kind == clnws_pkg::OP_WAIT) begin
      add_a       = op.hold;
      step.op_end = 1'b1;
    end else begin
      step.rs_line = op.rs;
      if (sub == clnws_pkg::SUB_HI_ON || sub == clnws_pkg::SUB_HI_OFF) begin
        step.data_nibble = op.data[7:4];
      end
      unique case (sub)
        clnws_pkg::SUB_HI_ON, clnws_pkg::SUB_LO_ON: begin
          add_a            = {8'd0, pulse_us};
          step.enable_line = 1'b1;
        end
        clnws_pkg::SUB_HI_OFF, clnws_pkg::SUB_LO_OFF: begin
          add_a       = {8'd0, pulse_us};
          add_b       = {8'd0, gap_us};
          step.op_end = (sub == clnws_pkg::SUB_LO_OFF) && (op.kind == clnws_pkg::OP_STROBE);
        end
        clnws_pkg::SUB_CMD_WAIT: begin
          add_a = {6'd0, cmd_wait_us};
        end
        clnws_pkg::SUB_RELEASE: begin
          step.rs_line = 1'b0;
          step.op_end  = 1'b1;
        end
        default: begin
          step.rs_line = 1'b0;
          step.op_end  = 1'b1;
        end
      endcase
    end
    // shared hold-time adder
    step.hold_us = add_a + add_b;
  end

endmodule

`default_nettype wire

// File: rtl/char_lcd_nibble_write_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel    handshake                  payload
// command    start / busy               item (func, data_byte, rs_select)
// result     strobe, one cycle          result (rs, enable, nibble, hold_us, last)
// config     cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one pin step per clock from the shared hold-time adder; a taken command moves the
// state register to run, from which the first result is registered into strobe and result
// byte write: 6 results, nibble write: 2, initialization: 38; busy stays high
// through the sequence and drops on the cycle the last result is shown
// an unused func code is taken and gives no results
// sync reset returns to idle and loads the default timings; results cannot be stalled

module char_lcd_nibble_write_sequencer_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  clnws_pkg::item_t                     item,
  output logic                                 strobe,
  output clnws_pkg::result_t                   result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [clnws_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [clnws_pkg::CFG_DATA_W-1:0]     cfg_data
);

  clnws_pkg::state_t                   state;
  clnws_pkg::state_t                   state_next;
  logic [clnws_pkg::OP_IDX_W-1:0]      op_idx;
  logic [clnws_pkg::OP_IDX_W-1:0]      op_idx_next;
  logic [clnws_pkg::SUB_W-1:0]         sub;
  logic [clnws_pkg::SUB_W-1:0]         sub_next;
  logic                                is_init;
  logic                                is_init_next;
  clnws_pkg::op_t                      user_op;
  logic [7:0]                          pulse_us;
  logic [7:0]                          gap_us;
  logic [9:0]                          cmd_wait_us;
  clnws_pkg::op_t                      cur_op;
  clnws_pkg::op_t                      next_init_op;
  clnws_pkg::step_t                    step;
  logic                                accept;
  logic                                func_ok;
  logic                                seq_end;
  logic                                emit;

  assign cfg_ready    = 1'b1;
  assign accept       = start && !busy;
  assign func_ok      = (item.func == clnws_pkg::FUNC_BYTE) ||
                        (item.func == clnws_pkg::FUNC_NIBBLE) ||
                        (item.func == clnws_pkg::FUNC_INIT);
  assign cur_op       = is_init ? clnws_pkg::init_op(op_idx) : user_op;
  assign next_init_op = clnws_pkg::init_op(op_idx + 4'd1);
  assign seq_end      = step.op_end && (!is_init || op_idx == clnws_pkg::INIT_LAST_OP);

  clnws_step u_step (
    .op          (cur_op),
    .sub         (sub),
    .pulse_us    (pulse_us),
    .gap_us      (gap_us),
    .cmd_wait_us (cmd_wait_us),
    .step        (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_us    <= clnws_pkg::PULSE_RESET;
      gap_us      <= clnws_pkg::GAP_RESET;
      cmd_wait_us <= clnws_pkg::CMD_WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == clnws_pkg::REG_PULSE) begin
        pulse_us <= cfg_data[7:0];
      end else if (cfg_index == clnws_pkg::REG_GAP) begin
        gap_us <= cfg_data[7:0];
      end else if (cfg_index == clnws_pkg::REG_CMD_WAIT) begin
        cmd_wait_us <= cfg_data;
      end else begin
        pulse_us <= pulse_us;
      end
    end
  end

  // next state
  always_comb begin
    state_next   = state;
    op_idx_next  = op_idx;
    sub_next     = sub;
    is_init_next = is_init;
    unique case (state)
      clnws_pkg::ST_IDLE: begin
        if (accept && func_ok) begin
          state_next   = clnws_pkg::ST_RUN;
          op_idx_next  = '0;
          is_init_next = (item.func == clnws_pkg::FUNC_INIT);
          sub_next     = (item.func == clnws_pkg::FUNC_NIBBLE) ?
                         clnws_pkg::SUB_LO_ON : clnws_pkg::SUB_HI_ON;
        end
      end
      clnws_pkg::ST_RUN: begin
        if (seq_end) begin
          state_next = clnws_pkg::ST_IDLE;
        end else if (step.op_end) begin
          op_idx_next = op_idx + 4'd1;
          sub_next    = clnws_pkg::first_sub(next_init_op.kind);
        end else begin
          sub_next = sub + 3'd1;
        end
      end
      default: state_next = clnws_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = 1'b0;
    emit = 1'b0;
    unique case (state)
      clnws_pkg::ST_IDLE: begin
        busy = 1'b0;
        emit = 1'b0;
      end
      clnws_pkg::ST_RUN: begin
        busy = 1'b1;
        emit = 1'b1;
      end
      default: begin
        busy = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= clnws_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    op_idx  <= op_idx_next;
    sub     <= sub_next;
    is_init <= is_init_next;
    if (accept) begin
      user_op.kind <= (item.func == clnws_pkg::FUNC_NIBBLE) ?
                      clnws_pkg::OP_STROBE : clnws_pkg::OP_BYTE;
      user_op.data <= item.data_byte;
      user_op.rs   <= (item.func == clnws_pkg::FUNC_BYTE) ? item.rs_select : 1'b0;
      user_op.hold <= 16'd0;
    end
    if (emit) begin
      result.rs_line     <= step.rs_line;
      result.enable_line <= step.enable_line;
      result.data_nibble <= step.data_nibble;
      result.hold_us     <= step.hold_us;
      result.last        <= seq_end;
    end
  end

  a_busy_fall_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> strobe && result.last)
    else $error("busy dropped without a final result");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("result directly after final result");

  a_enable_low_follows: assert property (@(posedge clk) disable iff (rst)
    strobe && result.enable_line |=> strobe && !result.enable_line)
    else $error("enable high not followed by enable low");

endmodule

`default_nettype wire

// File: sim/tb_char_lcd_nibble_write_sequencer_top.sv
`timescale 1ns / 1ps

module tb_char_lcd_nibble_write_sequencer_top;
  import clnws_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;
  localparam logic [15:0] POWER_WAIT = 16'd50000;
  localparam logic [15:0] SHORT_WAIT = 16'd50;
  localparam logic [15:0] LONG_WAIT = 16'd10000;

  typedef struct packed {
    item_t       cmd;
    logic        typed;
    logic [1:0]  n_typed;
    result_t     exp0;
    result_t     exp1;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  item_t item;
  logic strobe;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [7:0] pulse_us;
  logic [7:0] gap_us;
  logic [9:0] cmd_wait_us;
  result_t pin_steps_due[$];
  int fail_count = 0;

  dir_row_t directed [14] = '{
    '{'{FUNC_NIBBLE, 8'h00, 1'b0}, 1'b1, 2'd2,
      '{1'b0, 1'b1, 4'h0, 16'd2, 1'b0}, '{1'b0, 1'b0, 4'h0, 16'd7, 1'b1}},
    // rs_select ignored on a nibble write
    '{'{FUNC_NIBBLE, 8'hFF, 1'b1}, 1'b1, 2'd2,
      '{1'b0, 1'b1, 4'hF, 16'd2, 1'b0}, '{1'b0, 1'b0, 4'hF, 16'd7, 1'b1}},
    '{'{FUNC_NIBBLE, 8'hA5, 1'b1}, 1'b1, 2'd2,
      '{1'b0, 1'b1, 4'h5, 16'd2, 1'b0}, '{1'b0, 1'b0, 4'h5, 16'd7, 1'b1}},
    // unused func code gives nothing
    '{'{FUNC_UNUSED, 8'hFF, 1'b1}, 1'b1, 2'd0, '0, '0},
    '{'{FUNC_UNUSED, 8'h00, 1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{FUNC_BYTE, 8'h00, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{FUNC_BYTE, 8'hFF, 1'b1}, 1'b0, 2'd0, '0, '0},
    '{'{FUNC_BYTE, 8'h5A, 1'b1}, 1'b0, 2'd0, '0, '0},
    '{'{FUNC_BYTE, 8'hA5, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{FUNC_INIT, 8'h00, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{FUNC_NIBBLE, 8'h5A, 1'b0}, 1'b1, 2'd2,
      '{1'b0, 1'b1, 4'hA, 16'd2, 1'b0}, '{1'b0, 1'b0, 4'hA, 16'd7, 1'b1}},
    '{'{FUNC_BYTE, 8'h80, 1'b1}, 1'b0, 2'd0, '0, '0},
    '{'{FUNC_INIT, 8'hFF, 1'b1}, 1'b0, 2'd0, '0, '0},
    '{'{FUNC_BYTE, 8'h01, 1'b0}, 1'b0, 2'd0, '0, '0}
  };

  char_lcd_nibble_write_sequencer_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .strobe(strobe),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void push_step(input logic rs, input logic en, input logic [3:0] nib,
                                    input logic [15:0] hold);
    result_t r;
    r = '{rs_line: rs, enable_line: en, data_nibble: nib, hold_us: hold, last: 1'b0};
    pin_steps_due.push_back(r);
  endfunction

  function automatic void push_strobe(input logic rs, input logic [3:0] nib);
    push_step(rs, 1'b1, nib, {8'd0, pulse_us});
    push_step(rs, 1'b0, nib, {8'd0, pulse_us} + {8'd0, gap_us});
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] b);
    push_strobe(rs, b[7:4]);
    push_strobe(rs, b[3:0]);
    push_step(rs, 1'b0, b[3:0], {6'd0, cmd_wait_us});
    push_step(1'b0, 1'b0, b[3:0], 16'd0);
  endfunction

  function automatic void expand_command(input item_t cmd);
    int before_size;
    result_t tail;
    before_size = pin_steps_due.size();
    case (cmd.func)
      FUNC_BYTE: push_byte(cmd.rs_select, cmd.data_byte);
      FUNC_NIBBLE: push_strobe(1'b0, cmd.data_byte[3:0]);
      FUNC_INIT: begin
        push_step(1'b0, 1'b0, 4'h0, POWER_WAIT);
        push_strobe(1'b0, 4'h3);
        push_step(1'b0, 1'b0, 4'h3, SHORT_WAIT);
        push_byte(1'b0, 8'h28);
        push_step(1'b0, 1'b0, 4'h8, SHORT_WAIT);
        push_byte(1'b0, 8'h0E);
        push_step(1'b0, 1'b0, 4'hE, SHORT_WAIT);
        push_byte(1'b0, 8'h01);
        push_step(1'b0, 1'b0, 4'h1, LONG_WAIT);
        push_byte(1'b0, 8'h06);
        push_step(1'b0, 1'b0, 4'h6, LONG_WAIT);
        push_byte(1'b0, 8'h0C);
      end
      default: ;
    endcase
    if (pin_steps_due.size() > before_size) begin
      tail = pin_steps_due.pop_back();
      tail.last = 1'b1;
      pin_steps_due.push_back(tail);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_steps
    result_t want;
    if (!rst && strobe) begin
      if (pin_steps_due.size() == 0) begin
        $error("unexpected transaction: rs %0d en %0d nibble %0h hold %0d last %0d",
               result.rs_line, result.enable_line, result.data_nibble, result.hold_us,
               result.last);
        fail_count++;
      end else begin
        want = pin_steps_due.pop_front();
        check_field("rs_line", 32'(want.rs_line), 32'(result.rs_line));
        check_field("enable_line", 32'(want.enable_line), 32'(result.enable_line));
        check_field("data_nibble", 32'(want.data_nibble), 32'(result.data_nibble));
        check_field("hold_us", 32'(want.hold_us), 32'(result.hold_us));
        check_field("last", 32'(want.last), 32'(result.last));
      end
    end
  end

  task automatic issue(input item_t cmd);
    start <= 1'b1;
    item <= cmd;
    do @(posedge clk); while (busy);
    expand_command(cmd);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pin_steps_due.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PULSE: pulse_us = val[7:0];
      REG_GAP: gap_us = val[7:0];
      REG_CMD_WAIT: cmd_wait_us = val;
      default: ;
    endcase
  endtask

  initial begin
    item_t cmd;
    int counted;
    int pick;
    logic [9:0] p;
    logic [9:0] g;
    logic [9:0] w;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pulse_us = PULSE_RESET;
    gap_us = GAP_RESET;
    cmd_wait_us = CMD_WAIT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      start <= 1'b1;
      item <= directed[i].cmd;
      do @(posedge clk); while (busy);
      if (directed[i].typed) begin
        if (directed[i].n_typed > 0) pin_steps_due.push_back(directed[i].exp0);
        if (directed[i].n_typed > 1) pin_steps_due.push_back(directed[i].exp1);
      end else begin
        expand_command(directed[i].cmd);
      end
      if (i % 4 == 3) idle_cycles(3);
    end

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0: begin p = 10'd0; g = 10'd0; w = 10'd0; end
        1: begin p = 10'h3FF; g = 10'h3FF; w = 10'h3FF; end
        3: begin p = 10'd0; g = 10'h0FF; w = 10'h3FF; end
        4: begin p = 10'h0FF; g = 10'd0; w = 10'd0; end
        default: begin p = 10'($urandom); g = 10'($urandom); w = 10'($urandom); end
      endcase
      write_reg(REG_NONE, 10'($urandom));
      write_reg(REG_PULSE, p);
      write_reg(REG_GAP, g);
      write_reg(REG_CMD_WAIT, w);
      cfg_valid <= 1'b0;
      counted = 0;
      while (counted < 45) begin
        pick = $urandom_range(99);
        if (pick < 45) cmd.func = FUNC_BYTE;
        else if (pick < 80) cmd.func = FUNC_NIBBLE;
        else if (pick < 90) cmd.func = FUNC_INIT;
        else cmd.func = FUNC_UNUSED;
        cmd.data_byte = 8'($urandom_range(255));
        cmd.rs_select = 1'($urandom_range(1));
        if (cmd.func != FUNC_UNUSED) counted++;
        issue(cmd);
        // phase 2 runs back to back
        if (ph != 2 && $urandom_range(99) < 10) idle_cycles($urandom_range(1, 20));
        if (ph == 3 && counted == 25) settle();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("[char_lcd_nibble_write_sequencer_top] OK");
    end else begin
      $display("[char_lcd_nibble_write_sequencer_top] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[char_lcd_nibble_write_sequencer_top] ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/clnws_pkg.sv
rtl/clnws_step.sv
rtl/char_lcd_nibble_write_sequencer_top.sv
sim/tb_char_lcd_nibble_write_sequencer_top.sv
